[hw/rtl/wsfm_pkg.sv]
// Package: widths, thresholds, config layout and lane status for the wheel sensor fault monitor.
package wsfm_pkg;

  localparam int NUM_WHEELS  = 4;
  localparam int SPEED_W     = 16;
  localparam int CNT_W       = 16;
  localparam int FAULT_W     = 6;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 88;
  localparam int OUT_DATA_W  = 24;

  localparam logic [SPEED_W-1:0] MOVING_SPEED = SPEED_W'(500);
  localparam logic [SPEED_W-1:0] NEAR_ZERO    = SPEED_W'(10);
  localparam logic [SPEED_W-1:0] CLEAR_SPEED  = SPEED_W'(100);
  localparam logic [CNT_W-1:0]   CNT_MAX      = {CNT_W{1'b1}};

  localparam int BIT_REF  = 4;
  localparam int BIT_LOOP = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CIRCUIT_CYCLES     = 2'd0,
    CFG_IMPLAUSIBLE_CYCLES = 2'd1,
    CFG_RELEASE_CYCLES     = 2'd2,
    CFG_PLAUSIBLE_DELTA    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] circuit_cycles;
    logic [CFG_W-1:0] implausible_cycles;
    logic [CFG_W-1:0] release_cycles;
    logic [CFG_W-1:0] plausible_delta;
  } cfg_t;

  typedef struct packed {
    logic raise;
    logic clear;
    logic high;
    logic stuck;
  } wheel_stat_t;

endpackage

[hw/rtl/wheel_sensor_fault_monitor.sv]
// Top level: config registers, input register, wheel lanes, fault combine, result register.
//
//   channel | dir | handshake            | payload
//   s_      | in  | s_tvalid / s_tready  | s_tdata: speeds 0-3, reference, release mask
//   m_      | out | m_tvalid / m_tready  | m_tdata: active, raised, cleared
//   cfg_    | in  | cfg_we               | cfg_index, cfg_data
//
// One item per clock unless the result stalls; path: input register, then result register.
// The lane counters and fault mask update in the cycle an item moves from the
// input register into the result register.
// Reset clears all counters and faults and loads the threshold defaults.
// A stalled result holds; the input register still takes one more item.
module wheel_sensor_fault_monitor
  import wsfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3, reference_speed, release_mask
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // active_faults, raised_faults, cleared_faults
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cfg_t                         cfg;
  logic                         in_valid;
  logic [SPEED_W-1:0]           in_speed [NUM_WHEELS];
  logic [SPEED_W-1:0]           in_ref;
  logic [NUM_WHEELS-1:0]        in_rel;
  logic                         advance;
  logic                         step;
  logic                         moving;
  logic [SPEED_W:0]             limit;
  wheel_stat_t [NUM_WHEELS-1:0] stat;
  logic [FAULT_W-1:0]           flags;
  logic [FAULT_W-1:0]           flags_next;
  logic                         out_valid;
  logic [FAULT_W-1:0]           out_active;
  logic [FAULT_W-1:0]           out_raised;
  logic [FAULT_W-1:0]           out_cleared;

  assign advance  = !out_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign moving   = in_ref > MOVING_SPEED;
  assign limit    = {1'b0, in_ref} + {1'b0, cfg.plausible_delta};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.circuit_cycles     <= CFG_W'(10);
      cfg.implausible_cycles <= CFG_W'(10);
      cfg.release_cycles     <= CFG_W'(50);
      cfg.plausible_delta    <= CFG_W'(500);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CIRCUIT_CYCLES:     cfg.circuit_cycles     <= cfg_data;
        CFG_IMPLAUSIBLE_CYCLES: cfg.implausible_cycles <= cfg_data;
        CFG_RELEASE_CYCLES:     cfg.release_cycles     <= cfg_data;
        CFG_PLAUSIBLE_DELTA:    cfg.plausible_delta    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        in_speed[i] <= s_tdata[i*SPEED_W +: SPEED_W];
      end
      in_ref <= s_tdata[NUM_WHEELS*SPEED_W +: SPEED_W];
      in_rel <= s_tdata[(NUM_WHEELS+1)*SPEED_W +: NUM_WHEELS];
    end
  end

  for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_wheel
    wsfm_wheel u_wheel (
      .clk         (clk),
      .rst         (rst),
      .step        (step),
      .speed       (in_speed[g]),
      .moving      (moving),
      .limit       (limit),
      .release_bit (in_rel[g]),
      .cfg         (cfg),
      .stat        (stat[g])
    );
  end

  wsfm_faults u_faults (
    .clk                (clk),
    .rst                (rst),
    .step               (step),
    .stat               (stat),
    .implausible_cycles (cfg.implausible_cycles),
    .flags              (flags),
    .flags_next         (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_active  <= flags_next;
      out_raised  <= flags_next & ~flags;
      out_cleared <= flags & ~flags_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_DATA_W - 3*FAULT_W)'(0), out_cleared, out_raised, out_active};

`ifndef SYNTHESIS
  a_result_matches_mask: assert property (@(posedge clk) disable iff (rst)
    step |=> (out_active == flags))
    else $error("result mask differs from fault state");

  a_raised_in_active: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_raised & ~out_active) == '0))
    else $error("raised fault not active");

  a_cleared_not_active: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_cleared & out_active) == '0))
    else $error("cleared fault still active");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled with empty input register");
`endif

endmodule

[hw/rtl/wsfm_wheel.sv]
// One wheel lane: near-zero counter, release counter and per-wheel fault decisions.
module wsfm_wheel
  import wsfm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [SPEED_W-1:0] speed,
  input  logic               moving,
  input  logic [SPEED_W:0]   limit,
  input  logic               release_bit,
  input  cfg_t               cfg,
  output wheel_stat_t        stat
);

  logic [CNT_W-1:0] zero_cnt;
  logic [CNT_W-1:0] rel_cnt;
  logic [CNT_W-1:0] zero_inc;
  logic [CNT_W-1:0] rel_inc;
  logic             near;
  logic             fast;

  assign zero_inc = (zero_cnt == CNT_MAX) ? zero_cnt : zero_cnt + 1'b1;
  assign rel_inc  = (rel_cnt == CNT_MAX) ? rel_cnt : rel_cnt + 1'b1;
  assign near     = moving && (speed <= NEAR_ZERO);
  assign fast     = speed > CLEAR_SPEED;

  assign stat.raise = near && (zero_inc >= cfg.circuit_cycles);
  assign stat.clear = !near && fast;
  assign stat.high  = {1'b0, speed} > limit;
  assign stat.stuck = release_bit && (rel_inc >= cfg.release_cycles);

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_cnt <= '0;
      rel_cnt  <= '0;
    end else if (step) begin
      if (near) begin
        zero_cnt <= zero_inc;
      end else if (fast) begin
        zero_cnt <= '0;
      end
      rel_cnt <= release_bit ? rel_inc : '0;
    end
  end

endmodule

[hw/rtl/wsfm_faults.sv]
// Fault combine: implausibility counter and the active fault mask.
module wsfm_faults
  import wsfm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  wheel_stat_t [NUM_WHEELS-1:0] stat,
  input  logic [CFG_W-1:0]             implausible_cycles,
  output logic [FAULT_W-1:0]           flags,
  output logic [FAULT_W-1:0]           flags_next
);

  logic [CNT_W-1:0] imp_cnt;
  logic [CNT_W-1:0] imp_inc;
  logic             any_high;
  logic             any_stuck;

  assign imp_inc = (imp_cnt == CNT_MAX) ? imp_cnt : imp_cnt + 1'b1;

  always_comb begin
    any_high   = 1'b0;
    any_stuck  = 1'b0;
    flags_next = flags;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      any_high  = any_high | stat[i].high;
      any_stuck = any_stuck | stat[i].stuck;
      if (stat[i].raise) begin
        flags_next[i] = 1'b1;
      end else if (stat[i].clear) begin
        flags_next[i] = 1'b0;
      end
    end
    flags_next[BIT_REF]  = any_high && (flags[BIT_REF] || (imp_inc >= implausible_cycles));
    flags_next[BIT_LOOP] = any_stuck;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      imp_cnt <= '0;
      flags   <= '0;
    end else if (step) begin
      imp_cnt <= any_high ? imp_inc : '0;
      flags   <= flags_next;
    end
  end

endmodule
